@@ sv/i2a_pkg.sv @@
// Shared constants, types and helpers for the integer-to-ASCII text block.
package i2a_pkg;

  localparam int VALUE_WIDTH = 64;                        // value bits that take part
  localparam int NIBBLES     = (VALUE_WIDTH + 3) / 4;     // hex digits / dabble steps
  localparam int PAD_WIDTH   = NIBBLES * 4;               // magnitude padded to nibbles
  // ceil(VALUE_WIDTH * log10(2))
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;
  localparam int NDIG        = (DEC_DIGITS > NIBBLES) ? DEC_DIGITS : NIBBLES;
  localparam int IDX_W       = $clog2(NDIG);
  localparam int STEP_W      = (NIBBLES > 1) ? $clog2(NIBBLES) : 1;

  localparam int VALUE_FW    = 64;                        // value field width
  localparam int MODE_FW     = 2;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int S_TDATA_W   = ((VALUE_FW + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((CHAR_W + LEN_W + 7) / 8) * 8;

  localparam int QDEPTH      = 2;                         // power of two
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [MODE_FW-1:0] MODE_SDEC = 2'd0;
  localparam logic [MODE_FW-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_FW-1:0] MODE_SHEX = 2'd2;
  localparam logic [MODE_FW-1:0] MODE_UHEX = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;         // '0'
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;         // 'x'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;         // '-'
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;         // 'A' - 10
  localparam logic [3:0]        RADIX_DEC = 4'd10;

  typedef struct packed {
    logic [PAD_WIDTH-1:0] mag;
    logic                 neg;
    logic                 hex;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < RADIX_DEC) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

@@ sv/i2a_front.sv @@
// Front end: accepts input transactions, classifies sign and radix, forms the magnitude.
module i2a_front
  import i2a_pkg::*;
(
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // value [63:0]
  input  logic [MODE_FW-1:0]   s_axis_tuser_i,   // mode [1:0]
  input  qstat_t               qstat_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic [VALUE_WIDTH-1:0] value;
  logic [MODE_FW-1:0]     mode;
  logic                   is_signed;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  assign value = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign mode  = s_axis_tuser_i;

  assign is_signed = (mode == MODE_SDEC) || (mode == MODE_SHEX);
  assign neg       = is_signed && value[VALUE_WIDTH-1];
  // most negative value negates to itself, which is its unsigned magnitude
  assign mag       = neg ? (~value + VALUE_WIDTH'(1)) : value;

  assign s_axis_tready_o = !qstat_i.full;
  assign push_o          = s_axis_tvalid_i && !qstat_i.full;

  assign item_o.mag = PAD_WIDTH'(mag);
  assign item_o.neg = neg;
  assign item_o.hex = (mode == MODE_SHEX) || (mode == MODE_UHEX);

endmodule

@@ sv/i2a_queue.sv @@
// Short queue of classified items between front and back end.
module i2a_queue
  import i2a_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));

endmodule

@@ sv/i2a_back.sv @@
// Back end: binary-to-BCD conversion, digit count and character emission.
module i2a_back
  import i2a_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  item_t                item_i,
  input  qstat_t               qstat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // char_out [7:0], text_length [12:8]
  output logic                 m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  logic [NDIG-1:0][3:0]       dig_q;
  logic [NDIG-1:0][3:0]       dig_d;
  logic [PAD_WIDTH-1:0]       sh_q;
  logic [PAD_WIDTH-1:0]       sh_d;
  logic [STEP_W-1:0]          step_q;
  logic                       neg_q;
  logic                       hex_q;
  logic [LEN_W-1:0]           len_q;
  logic [LEN_W-1:0]           pre_q;
  logic [LEN_W-1:0]           cnt_q;
  logic [LEN_W-1:0]           ndig;
  logic [LEN_W-1:0]           pre;
  logic [LEN_W-1:0]           di;
  logic [CHAR_W-1:0]          ch;
  logic                       is_last;
  logic                       out_free;
  logic [CHAR_W-1:0]          char_q;
  logic [LEN_W-1:0]           olen_q;
  logic                       ovalid_q;
  logic                       olast_q;
  logic [NDIG-1:0][3:0]       hex_dig;

  // four double-dabble bit steps per cycle
  always_comb begin
    dig_d = dig_q;
    sh_d  = sh_q;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (dig_d[i] >= 4'd5) begin
          dig_d[i] = dig_d[i] + 4'd3;
        end
      end
      for (int i = NDIG - 1; i > 0; i--) begin
        dig_d[i] = {dig_d[i][2:0], dig_d[i-1][3]};
      end
      dig_d[0] = {dig_d[0][2:0], sh_d[PAD_WIDTH-1]};
      sh_d     = {sh_d[PAD_WIDTH-2:0], 1'b0};
    end
  end

  always_comb begin
    hex_dig = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      hex_dig[i] = item_i.mag[4*i +: 4];
    end
  end

  // digits in the text: highest nonzero position, at least one
  always_comb begin
    ndig = LEN_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (dig_q[i] != 4'd0) begin
        ndig = LEN_W'(i + 1);
      end
    end
  end

  assign pre = LEN_W'(neg_q) + (hex_q ? LEN_W'(2) : LEN_W'(0));
  assign di  = len_q - LEN_W'(1) - cnt_q;

  always_comb begin
    if (cnt_q >= pre_q) begin
      ch = digit_char(dig_q[di[IDX_W-1:0]]);
    end else if (neg_q && (cnt_q == '0)) begin
      ch = CH_MINUS;
    end else if (cnt_q == LEN_W'(neg_q)) begin
      ch = CH_ZERO;
    end else begin
      ch = CH_X;
    end
  end

  assign is_last  = (cnt_q == len_q - LEN_W'(1));
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dig_q    <= '0;
      sh_q     <= '0;
      step_q   <= '0;
      neg_q    <= 1'b0;
      hex_q    <= 1'b0;
      len_q    <= '0;
      pre_q    <= '0;
      cnt_q    <= '0;
      char_q   <= '0;
      olen_q   <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      if ((state_q == ST_EMIT) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!qstat_i.empty) begin
            neg_q  <= item_i.neg;
            hex_q  <= item_i.hex;
            sh_q   <= item_i.mag;
            step_q <= STEP_W'(NIBBLES - 1);
            if (item_i.hex) begin
              dig_q   <= hex_dig;
              state_q <= ST_SCAN;
            end else begin
              dig_q   <= '0;
              state_q <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          dig_q  <= dig_d;
          sh_q   <= sh_d;
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pre_q   <= pre;
          len_q   <= pre + ndig;
          cnt_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            char_q   <= ch;
            olast_q  <= is_last;
            olen_q   <= is_last ? len_q : '0;
            cnt_q    <= cnt_q + LEN_W'(1);
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = M_TDATA_W'({olen_q, char_q});

endmodule

@@ sv/int_to_ascii_text.sv @@
// Top level: integer to ASCII text converter, decimal or hex, signed or unsigned.
//
//  channel  dir  tdata                               tuser        tlast
//  s_axis   in   [63:0] value                        [1:0] mode   -
//  m_axis   out  [7:0] char_out, [12:8] text_length  -            last character of the text
//
// Decimal: IDLE dequeues, CONV runs double dabble at four bits a cycle, SCAN counts the
// digits, then EMIT sends one character per cycle while the output is not stalled.
// Hex: IDLE loads the nibbles as digits and goes straight to SCAN, then EMIT. The back end
// works on one value at a time; the front end keeps accepting into a two-entry queue meanwhile.
// Reset clears the queue, the sequencer and the output register.
// An output stall holds the sequencer in EMIT; input stalls only when the queue is full.
module int_to_ascii_text
  import i2a_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // value [63:0]
  input  logic [MODE_FW-1:0]   s_axis_tuser_i,   // mode [1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // char_out [7:0], text_length [12:8]
  output logic                 m_axis_tlast_o
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  item_t  push_item;
  item_t  pop_item;

  i2a_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (push_item)
  );

  i2a_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (qstat)
  );

  i2a_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (pop_item),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_last_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[12:8] != 5'd0) && (m_axis_tdata_o[12:8] <= 5'd20))
    else $error("last character without a valid text length");

  a_mid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[12:8] == 5'd0))
    else $error("text length set on a non-final character");

  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !qstat.empty)
    else $error("accepted transaction did not reach the queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

@@ tb/tb_int_to_ascii_text.sv @@
`timescale 1ns / 1ps
// Testbench for int_to_ascii_text: predicts the text of each value and checks every character.
module tb_int_to_ascii_text
  import i2a_pkg::*;
;

  localparam int  CLK_PERIOD  = 20;
  localparam int  RESET_LEN   = 9;
  localparam int  TAIL_CYCLES = 64;
  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  RAND_BLOCKS = 5;
  localparam int  BLOCK_ITEMS = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [LEN_W-1:0]  len;
  } glyph_t;

  // Expected characters of every accepted value, oldest first.
  class text_scoreboard;
    glyph_t pending_chars[$];
    int     errors;
    int     chars_checked;
    int     values_per_mode[4];

    function void note_value(logic [VALUE_FW-1:0] value, logic [MODE_FW-1:0] mode);
      logic [VALUE_FW-1:0] mag;
      logic [CHAR_W-1:0]   text[$];
      logic [CHAR_W-1:0]   digits[$];
      logic [3:0]          d;
      bit                  is_hex;
      bit                  is_neg;
      glyph_t              g;
      is_hex = (mode == MODE_SHEX) || (mode == MODE_UHEX);
      is_neg = ((mode == MODE_SDEC) || (mode == MODE_SHEX)) && value[VALUE_FW-1];
      // most negative value wraps back onto itself, read as unsigned it is exact
      mag = is_neg ? (~value + 1'b1) : value;
      if (is_neg) text.push_back(CH_MINUS);
      if (is_hex) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end
      do begin
        d = is_hex ? mag[3:0] : 4'(mag % 10);
        if (d < 4'd10) digits.push_front(CH_ZERO + CHAR_W'(d));
        else digits.push_front(CHAR_W'("A") + CHAR_W'(d) - CHAR_W'(10));
        mag = is_hex ? (mag >> 4) : (mag / 10);
      end while (mag != '0);
      text = {text, digits};
      foreach (text[k]) begin
        g.ch   = text[k];
        g.last = (k == text.size() - 1);
        g.len  = g.last ? LEN_W'(text.size()) : '0;
        pending_chars.push_back(g);
      end
      values_per_mode[mode]++;
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last, logic [LEN_W-1:0] len);
      glyph_t exp_g;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character 0x%02h last %0b len %0d, nothing pending",
                 $time, ch, last, len);
        errors++;
        return;
      end
      exp_g = pending_chars.pop_front();
      chars_checked++;
      if (ch !== exp_g.ch) begin
        $display("%0t: char mismatch: expected 0x%02h '%c', got 0x%02h '%c'",
                 $time, exp_g.ch, exp_g.ch, ch, ch);
        errors++;
      end
      if (last !== exp_g.last) begin
        $display("%0t: tlast mismatch: expected %0b, got %0b", $time, exp_g.last, last);
        errors++;
      end
      if (len !== exp_g.len) begin
        $display("%0t: text_length mismatch: expected %0d, got %0d", $time, exp_g.len, len);
        errors++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // value [63:0]
  logic [MODE_FW-1:0]   s_axis_tuser;   // mode [1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // char_out [7:0], text_length [12:8]
  logic                 m_axis_tlast;

  text_scoreboard board;
  bit             calm;          // no random idling on either side while set
  int             rx_hold;       // long receiver hold-off, counted down by the receiver
  int             cycle_count;

  int_to_ascii_text i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_FW-1:0] pick_value();
    logic [VALUE_FW-1:0] v;
    int                  sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = VALUE_FW'($urandom_range(0, 20));
      1: v = -VALUE_FW'($urandom_range(1, 20));
      2: begin
        // around a power of ten
        v = 1;
        repeat ($urandom_range(0, 19)) v = v * 10;
        v = v + VALUE_FW'($urandom_range(0, 2)) - 1'b1;
      end
      3: v = (VALUE_FW'(1) << (4 * $urandom_range(0, 15))) + VALUE_FW'($urandom_range(0, 2))
             - 1'b1;
      4: v = VALUE_FW'({1'b1, VALUE_FW'($urandom_range(0, 3))} >> 1);   // near the most negative
      5: v = {32'h0, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [VALUE_FW-1:0] value, input logic [MODE_FW-1:0] mode);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = S_TDATA_W'({$urandom, $urandom});
      s_axis_tuser  = MODE_FW'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tdata[VALUE_FW-1:0] = value;
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_value(value, mode);
  endtask

  task automatic send_all_modes(input logic [VALUE_FW-1:0] value);
    send_value(value, MODE_SDEC);
    send_value(value, MODE_UDEC);
    send_value(value, MODE_SHEX);
    send_value(value, MODE_UHEX);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall_left    = idle_len() - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_char(m_axis_tdata[CHAR_W-1:0], m_axis_tlast,
                       m_axis_tdata[CHAR_W+LEN_W-1:CHAR_W]);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still pending",
               cycle_count, board.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    board         = new();
    calm          = 1'b0;
    rx_hold       = 0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (RESET_LEN) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, all ones, most negative, most positive, digit and prefix edges
    send_all_modes('0);
    send_all_modes('1);
    send_all_modes({1'b1, {(VALUE_FW-1){1'b0}}});
    send_value({1'b0, {(VALUE_FW-1){1'b1}}}, MODE_SDEC);
    send_value({1'b0, {(VALUE_FW-1){1'b1}}}, MODE_SHEX);
    send_value(64'd9, MODE_UDEC);
    send_value(64'd10, MODE_SDEC);
    send_value(64'd15, MODE_UHEX);
    send_value(64'd16, MODE_SHEX);
    send_value(64'hABCD_EF01_2345_6789, MODE_UHEX);
    send_value(64'd999_999_999_999_999_999, MODE_SDEC);
    send_value(64'd1_000_000_000_000_000_000, MODE_UDEC);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // receiver holds off long while values keep coming, so the input backs up
    rx_hold = 300;
    calm    = 1'b1;
    repeat (8) send_value(pick_value(), MODE_FW'($urandom_range(0, 3)));
    calm    = 1'b0;

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      calm = (b % 2 == 1);
      repeat (BLOCK_ITEMS) send_value(pick_value(), MODE_FW'($urandom_range(0, 3)));
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d values: %0d signed dec, %0d unsigned dec, %0d signed hex,",
             board.values_per_mode[0] + board.values_per_mode[1] + board.values_per_mode[2]
             + board.values_per_mode[3], board.values_per_mode[MODE_SDEC],
             board.values_per_mode[MODE_UDEC], board.values_per_mode[MODE_SHEX]);
    $display("%0d unsigned hex; %0d characters checked under random stalls on both sides",
             board.values_per_mode[MODE_UHEX], board.chars_checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
